[rtl/core/iufc_pkg.sv]
// Shared constants, types and the ones' complement fold for the IPv4/UDP checksum block.
package iufc_pkg;

    localparam int DEFAULT_MAX_FRAME_BYTES = 2048;

    // Frame layout, in bytes from the start of the Ethernet header
    localparam int ETH_HDR_BYTES   = 14;
    localparam int IP_HDR_BYTES    = 20;
    localparam int UDP_HDR_START   = ETH_HDR_BYTES + IP_HDR_BYTES;
    localparam int MIN_FRAME_BYTES = 42;

    // IPv4 header offsets: zeroed length and checksum bytes, start of the addresses
    localparam int IP_LEN_HI   = 2;
    localparam int IP_LEN_LO   = 3;
    localparam int IP_CKSUM_HI = 10;
    localparam int IP_CKSUM_LO = 11;
    localparam int IP_ADDR_OFS = 12;

    // Offsets inside the UDP header whose bytes are taken as zero
    localparam int UDP_ZERO_FIRST = 4;
    localparam int UDP_ZERO_LAST  = 7;

    localparam int IP_SUM_W  = 20;
    localparam int UDP_SUM_W = 28;
    localparam int FOLD_IN_W = 29;
    localparam int LEN_W     = 11;
    localparam int CKSUM_W   = 16;

    localparam logic [CKSUM_W-1:0] PROTO_WORD = 16'h0011;
    localparam logic [CKSUM_W-1:0] CKSUM_ONES = 16'hFFFF;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_SHORT = 2'd1,
        STATUS_LONG  = 2'd2
    } frame_status_t;

    // Running sums of one finished frame, handed from accumulator to finisher
    typedef struct packed {
        logic [IP_SUM_W-1:0]  ip_sum;
        logic [UDP_SUM_W-1:0] udp_sum;
        logic [7:0]           held_high_byte;
        logic                 overflowed;
    } sum_snap_t;

    // Two end-around-carry folds bring a 29-bit sum down to 16 bits
    function automatic logic [CKSUM_W-1:0] fold16(input logic [FOLD_IN_W-1:0] s);
        logic [CKSUM_W:0] r;
        r = (CKSUM_W+1)'(s[CKSUM_W-1:0]) + (CKSUM_W+1)'(s[FOLD_IN_W-1:CKSUM_W]);
        fold16 = r[CKSUM_W-1:0] + CKSUM_W'(r[CKSUM_W]);
    endfunction

endpackage

[rtl/core/iufc_accum.sv]
// Byte accumulator: running header and UDP sums, snapshot register per frame.
module iufc_accum
    import iufc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = DEFAULT_MAX_FRAME_BYTES,
    parameter int POS_W           = $clog2(MAX_FRAME_BYTES + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       frame_byte,
    input  logic             last_byte,
    output logic             snap_valid,
    input  logic             snap_ready,
    output logic [POS_W-1:0] snap_pos,
    output sum_snap_t        snap
);

    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [IP_SUM_W-1:0]  ip_sum_reg, ip_sum_next;
    logic [UDP_SUM_W-1:0] udp_sum_reg, udp_sum_next;
    logic [7:0]           held_reg, held_next;
    logic                 ovf_reg, ovf_next;
    logic                 snap_valid_reg;
    logic [POS_W-1:0]     snap_pos_reg;
    sum_snap_t            snap_reg;

    logic                 in_take;
    logic                 in_ip_hdr;
    logic [4:0]           ip_ofs;
    logic                 ip_skip;
    logic [15:0]          ip_word;
    logic [POS_W-1:0]     udp_ofs;
    logic [7:0]           udp_byte;

    assign in_ready = !snap_valid_reg || snap_ready;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        in_ip_hdr = (pos_reg >= POS_W'(ETH_HDR_BYTES)) && (pos_reg < POS_W'(UDP_HDR_START));
        ip_ofs    = 5'(pos_reg - POS_W'(ETH_HDR_BYTES));
        ip_skip   = (ip_ofs == 5'(IP_LEN_HI)) || (ip_ofs == 5'(IP_LEN_LO)) ||
                    (ip_ofs == 5'(IP_CKSUM_HI)) || (ip_ofs == 5'(IP_CKSUM_LO));
        ip_word   = ip_ofs[0] ? {8'h00, frame_byte} : {frame_byte, 8'h00};
        udp_ofs   = pos_reg - POS_W'(UDP_HDR_START);
        udp_byte  = ((udp_ofs >= POS_W'(UDP_ZERO_FIRST)) &&
                     (udp_ofs <= POS_W'(UDP_ZERO_LAST))) ? 8'h00 : frame_byte;

        pos_next     = pos_reg;
        ip_sum_next  = ip_sum_reg;
        udp_sum_next = udp_sum_reg;
        held_next    = held_reg;
        ovf_next     = ovf_reg;

        if (pos_reg < POS_W'(MAX_FRAME_BYTES))
        begin
            pos_next = pos_reg + POS_W'(1);
            if (in_ip_hdr)
            begin
                if (!ip_skip)
                begin
                    ip_sum_next = ip_sum_reg + IP_SUM_W'(ip_word);
                    if (ip_ofs >= 5'(IP_ADDR_OFS))
                    begin
                        udp_sum_next = udp_sum_reg + UDP_SUM_W'(ip_word);
                    end
                end
            end
            else if (pos_reg >= POS_W'(UDP_HDR_START))
            begin
                if (!udp_ofs[0])
                begin
                    held_next = udp_byte;
                end
                else
                begin
                    udp_sum_next = udp_sum_reg + UDP_SUM_W'({held_reg, udp_byte});
                end
            end
        end
        else
        begin
            ovf_next = 1'b1;
        end
    end

    // Frame state and snapshot flag; state clears after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            ip_sum_reg     <= '0;
            udp_sum_reg    <= '0;
            held_reg       <= '0;
            ovf_reg        <= 1'b0;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                if (last_byte)
                begin
                    pos_reg     <= '0;
                    ip_sum_reg  <= '0;
                    udp_sum_reg <= '0;
                    held_reg    <= '0;
                    ovf_reg     <= 1'b0;
                end
                else
                begin
                    pos_reg     <= pos_next;
                    ip_sum_reg  <= ip_sum_next;
                    udp_sum_reg <= udp_sum_next;
                    held_reg    <= held_next;
                    ovf_reg     <= ovf_next;
                end
            end
            if (in_take && last_byte)
            begin
                snap_valid_reg <= 1'b1;
            end
            else if (snap_ready)
            begin
                snap_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take && last_byte)
        begin
            snap_pos_reg            <= pos_next;
            snap_reg.ip_sum         <= ip_sum_next;
            snap_reg.udp_sum        <= udp_sum_next;
            snap_reg.held_high_byte <= held_next;
            snap_reg.overflowed     <= ovf_next;
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap_pos   = snap_pos_reg;
    assign snap       = snap_reg;

endmodule

[rtl/core/iufc_finish.sv]
// Finisher: lengths, folds and status from a frame snapshot into the result register.
module iufc_finish
    import iufc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = DEFAULT_MAX_FRAME_BYTES,
    parameter int POS_W           = $clog2(MAX_FRAME_BYTES + 1)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               snap_valid,
    output logic               snap_ready,
    input  logic [POS_W-1:0]   snap_pos,
    input  sum_snap_t          snap,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [LEN_W-1:0]   ip_total_length,
    output logic [LEN_W-1:0]   udp_length,
    output logic [CKSUM_W-1:0] ip_checksum,
    output logic [CKSUM_W-1:0] udp_checksum,
    output logic [1:0]         frame_status
);

    localparam int LW = (POS_W > LEN_W) ? POS_W : LEN_W;

    logic                 out_valid_reg;
    logic [LEN_W-1:0]     ip_len_reg;
    logic [LEN_W-1:0]     udp_len_reg;
    logic [CKSUM_W-1:0]   ip_ck_reg;
    logic [CKSUM_W-1:0]   udp_ck_reg;
    frame_status_t        status_reg;

    logic                 snap_take;
    logic                 short_frame;
    logic [LW-1:0]        ip_len;
    logic [LW-1:0]        udp_len;
    logic [FOLD_IN_W-1:0] ip_fold_in;
    logic [FOLD_IN_W-1:0] udp_fold_in;
    logic [CKSUM_W-1:0]   ip_ck;
    logic [CKSUM_W-1:0]   udp_ck_raw;
    logic [CKSUM_W-1:0]   udp_ck;
    frame_status_t        status;

    assign snap_ready = !out_valid_reg || out_ready;
    assign snap_take  = snap_valid && snap_ready;

    always_comb
    begin
        short_frame = snap_pos < POS_W'(MIN_FRAME_BYTES);
        ip_len      = LW'(snap_pos) - LW'(ETH_HDR_BYTES);
        udp_len     = LW'(snap_pos) - LW'(UDP_HDR_START);
        ip_fold_in  = FOLD_IN_W'(snap.ip_sum) + FOLD_IN_W'(ip_len);
        // odd UDP length: the held byte is the high half of a padded word
        udp_fold_in = FOLD_IN_W'(snap.udp_sum) + FOLD_IN_W'(PROTO_WORD) +
                      FOLD_IN_W'({udp_len, 1'b0}) +
                      (udp_len[0] ? FOLD_IN_W'({snap.held_high_byte, 8'h00})
                                  : FOLD_IN_W'(0));
        ip_ck       = ~fold16(ip_fold_in);
        udp_ck_raw  = ~fold16(udp_fold_in);
        udp_ck      = (udp_ck_raw == '0) ? CKSUM_ONES : udp_ck_raw;
        if (short_frame)
        begin
            status = STATUS_SHORT;
        end
        else if (snap.overflowed)
        begin
            status = STATUS_LONG;
        end
        else
        begin
            status = STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (snap_ready)
        begin
            out_valid_reg <= snap_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_take)
        begin
            status_reg <= status;
            if (short_frame)
            begin
                ip_len_reg  <= '0;
                udp_len_reg <= '0;
                ip_ck_reg   <= '0;
                udp_ck_reg  <= '0;
            end
            else
            begin
                ip_len_reg  <= ip_len[LEN_W-1:0];
                udp_len_reg <= udp_len[LEN_W-1:0];
                ip_ck_reg   <= ip_ck;
                udp_ck_reg  <= udp_ck;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign ip_total_length = ip_len_reg;
    assign udp_length      = udp_len_reg;
    assign ip_checksum     = ip_ck_reg;
    assign udp_checksum    = udp_ck_reg;
    assign frame_status    = status_reg;

endmodule

[rtl/core/ipv4_udp_frame_checksum.sv]
// Top level of the IPv4/UDP frame length and checksum generator.
//
// Input channel (in_valid/in_ready): one frame byte per transfer in wire order,
// last_byte high on the final byte. Layout: 14-byte Ethernet header, 20-byte
// IPv4 header without options, then UDP header and payload. Length and
// checksum fields of the incoming headers are ignored (summed as zero).
// Output channel (out_valid/out_ready): one transfer per frame carrying the
// IPv4 total length, UDP length, IPv4 header checksum, UDP checksum (pseudo
// header included, zero sent as all ones) and a status: ok, short (under 42
// bytes, all other fields zero) or long (bytes past MAX_FRAME_BYTES dropped).
// Throughput: one byte per cycle, frames back to back, while in_ready stays high.
// Path: the last byte's transfer loads the accumulator's snapshot register;
// the snapshot then loads the finisher's result register once that register
// is free (empty or being read by out_ready), which raises out_valid.
// Stall: a result waiting on out_ready holds; the snapshot register takes the
// next frame's result, and in_ready drops only while both are full.
// Reset: sums, byte count and both valid flags clear; no result is pending.
module ipv4_udp_frame_checksum
    import iufc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = DEFAULT_MAX_FRAME_BYTES
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         frame_byte,
    input  logic               last_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [LEN_W-1:0]   ip_total_length,
    output logic [LEN_W-1:0]   udp_length,
    output logic [CKSUM_W-1:0] ip_checksum,
    output logic [CKSUM_W-1:0] udp_checksum,
    output logic [1:0]         frame_status
);

    // byte count must reach MAX_FRAME_BYTES itself
    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);

    logic             snap_valid;
    logic             snap_ready;
    logic [POS_W-1:0] snap_pos;
    sum_snap_t        snap;

    iufc_accum #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
        .POS_W           (POS_W)
    ) u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .frame_byte (frame_byte),
        .last_byte  (last_byte),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap_pos   (snap_pos),
        .snap       (snap)
    );

    iufc_finish #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
        .POS_W           (POS_W)
    ) u_finish (
        .clk             (clk),
        .rst_n           (rst_n),
        .snap_valid      (snap_valid),
        .snap_ready      (snap_ready),
        .snap_pos        (snap_pos),
        .snap            (snap),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .ip_total_length (ip_total_length),
        .udp_length      (udp_length),
        .ip_checksum     (ip_checksum),
        .udp_checksum    (udp_checksum),
        .frame_status    (frame_status)
    );

endmodule

[rtl/core/iufc_checker.sv]
// Port-level assertions for the IPv4/UDP checksum block, bound to the top level.
module iufc_checker
    import iufc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic [7:0]         frame_byte,
    input logic               last_byte,
    input logic               out_valid,
    input logic               out_ready,
    input logic [LEN_W-1:0]   ip_total_length,
    input logic [LEN_W-1:0]   udp_length,
    input logic [CKSUM_W-1:0] ip_checksum,
    input logic [CKSUM_W-1:0] udp_checksum,
    input logic [1:0]         frame_status
);

    // stalled result stays put: checksums, status and UDP length
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(ip_checksum) &&
            $stable(udp_checksum) && $stable(frame_status) && $stable(udp_length))
        else $error("result changed while stalled");

    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_status == STATUS_SHORT |->
            ip_total_length == '0 && udp_length == '0 &&
            ip_checksum == '0 && udp_checksum == '0)
        else $error("short frame with non-zero fields");

    a_udp_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_status != STATUS_SHORT |-> udp_checksum != '0)
        else $error("zero UDP checksum sent");

    // both lengths come from the same byte count
    a_len_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_status != STATUS_SHORT |->
            ip_total_length == LEN_W'(udp_length + LEN_W'(IP_HDR_BYTES)))
        else $error("IPv4 and UDP lengths disagree");

endmodule

bind ipv4_udp_frame_checksum iufc_checker u_iufc_checker (.*);
